[rtl/core/cpvp_pkg.sv]
// Shared constants and types for the cascaded position/velocity PI servo block.
package cpvp_pkg;

  localparam int unsigned AXES      = 2;
  localparam int unsigned AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic [LIMIT_W-1:0]       limit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A         = 3'd0,
    REG_COEF_B         = 3'd1,
    REG_COEF_C         = 3'd2,
    REG_COEF_D         = 3'd3,
    REG_POSITION_GAIN  = 3'd4,
    REG_VELOCITY_LIMIT = 3'd5,
    REG_CURRENT_LIMIT  = 3'd6
  } cfg_idx_e;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

[rtl/core/cpvp_if.sv]
// Valid/ready channel interfaces: servo input item, servo result, register write.
interface cpvp_in_if import cpvp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic                   axis;
  logic signed [DATA_W-1:0] position_ref;
  logic signed [DATA_W-1:0] position_meas;
  logic signed [DATA_W-1:0] velocity_ref;
  logic signed [DATA_W-1:0] velocity_meas;

  modport source (output valid, action, axis, position_ref, position_meas,
                  velocity_ref, velocity_meas, input ready);
  modport sink   (input valid, action, axis, position_ref, position_meas,
                  velocity_ref, velocity_meas, output ready);
endinterface

interface cpvp_out_if import cpvp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DATA_W-1:0] current_cmd;
  logic                   current_clamped;

  modport source (output valid, current_cmd, current_clamped, input ready);
  modport sink   (input valid, current_cmd, current_clamped, output ready);
endinterface

interface cpvp_cfg_if import cpvp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/cascade_position_velocity_pi.sv]
// Cascaded position/velocity PI servo step, Q16.16, one shared multiplier and adder.
//
// Channels: in_i takes one servo item (mode, axis, references, measurements),
// out_o returns one current command plus a clamp flag per item, cfg_i writes
// the coefficient and limit registers (always ready, unknown indexes ignored).
// All are valid/ready; a transaction completes when both are high at a clock edge.
// The user must write registers only while no item is in flight; the block does not enforce this.
//
// One item runs through a ten-step sequencer that reuses a single 32x32 signed
// multiplier (product registered) and a single saturating adder. in_i.ready is
// high only in the idle state, so a new item is taken only after the last one
// has left the final step.
// The result sits in an output register: the next item may be accepted while
// it waits. If the receiver still stalls when the next result is finished,
// the sequencer holds in its last step until the register frees up.
//
// Reset (rst_ni low, asynchronous) clears the per-axis PI states to zero, the
// coefficients to zero and both limits to their maximum, and drops out_o.valid.
module cascade_position_velocity_pi import cpvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpvp_in_if.sink     in_i,
  cpvp_out_if.source  out_o,
  cpvp_cfg_if.sink    cfg_i
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ERRP = 11'b000_0000_0010,
    ST_MULG = 11'b000_0000_0100,
    ST_VCLP = 11'b000_0000_1000,
    ST_ERRV = 11'b000_0001_0000,
    ST_MULC = 11'b000_0010_0000,
    ST_MULD = 11'b000_0100_0000,
    ST_SUMO = 11'b000_1000_0000,
    ST_MULB = 11'b001_0000_0000,
    ST_SUMX = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_e;

  function automatic q16_t sat_shift(input logic signed [2*DATA_W-1:0] p);
    logic [16:0] hi;
    hi = p[2*DATA_W-1:47];
    if (&hi || ~|hi) return p[47:16];
    else if (p[2*DATA_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
    else return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // clamp to +/- lim, flag when the limit acts
  function automatic logic [DATA_W:0] clamp_sym(input q16_t v, input limit_t lim);
    logic signed [DATA_W:0] vw, lp, ln;
    vw = {v[DATA_W-1], v};
    lp = {2'b00, lim};
    ln = -lp;
    if (vw > lp) return {1'b1, lp[DATA_W-1:0]};
    else if (vw < ln) return {1'b1, ln[DATA_W-1:0]};
    else return {1'b0, v};
  endfunction

  state_e state_q, state_d;

  q16_t   coef_a_q, coef_b_q, coef_c_q, coef_d_q, gain_q;
  limit_t vlim_q, ilim_q;
  q16_t   pi_state_q [AXES];

  logic              action_q;
  logic [AXIS_W-1:0] axis_q;
  q16_t              pref_q, pmeas_q, vref_in_q, vmeas_q;
  q16_t              x_q, acc_q, err_q, t_q, cur_q;
  logic signed [2*DATA_W-1:0] prod_q;

  logic              out_valid_q;
  q16_t              out_cmd_q;
  logic              out_clamped_q;

  logic              in_acc, cfg_acc, out_free;
  logic [AXIS_W-1:0] axis_idx;

  // shared units
  q16_t                   mul_a, mul_b;
  logic signed [2*DATA_W-1:0] mul_p;
  q16_t                   add_a, add_b, add_y;
  logic                   add_sub;
  logic signed [DATA_W:0] add_w;
  q16_t                   prod_sh;
  logic [DATA_W:0]        vclamp, iclamp;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.current_cmd     = out_cmd_q;
  assign out_o.current_clamped = out_clamped_q;

  always_comb begin
    if (AXES > 1) axis_idx = AXIS_W'(in_i.axis);
    else axis_idx = '0;
  end

  always_comb begin
    unique case (state_q)
      ST_MULG: begin mul_a = gain_q;   mul_b = acc_q; end
      ST_MULC: begin mul_a = coef_c_q; mul_b = x_q;   end
      ST_MULD: begin mul_a = coef_d_q; mul_b = err_q; end
      ST_SUMO: begin mul_a = coef_a_q; mul_b = x_q;   end
      default: begin mul_a = coef_b_q; mul_b = err_q; end
    endcase
  end
  // operands sign-extended to the product width
  assign mul_p   = (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_b);
  assign prod_sh = sat_shift(prod_q);

  always_comb begin
    unique case (state_q)
      ST_ERRP: begin add_a = pref_q; add_b = pmeas_q; add_sub = 1'b1; end
      ST_ERRV: begin add_a = acc_q;  add_b = vmeas_q; add_sub = 1'b1; end
      default: begin add_a = t_q;    add_b = prod_sh; add_sub = 1'b0; end
    endcase
  end

  always_comb begin
    if (add_sub) add_w = {add_a[DATA_W-1], add_a} - {add_b[DATA_W-1], add_b};
    else add_w = {add_a[DATA_W-1], add_a} + {add_b[DATA_W-1], add_b};
    if (add_w[DATA_W] != add_w[DATA_W-1])
      add_y = add_w[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      add_y = add_w[DATA_W-1:0];
  end

  assign vclamp = clamp_sym(action_q ? vref_in_q : prod_sh, vlim_q);
  assign iclamp = clamp_sym(cur_q, ilim_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ERRP;
      ST_ERRP: state_d = ST_MULG;
      ST_MULG: state_d = ST_VCLP;
      ST_VCLP: state_d = ST_ERRV;
      ST_ERRV: state_d = ST_MULC;
      ST_MULC: state_d = ST_MULD;
      ST_MULD: state_d = ST_SUMO;
      ST_SUMO: state_d = ST_MULB;
      ST_MULB: state_d = ST_SUMX;
      ST_SUMX: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      gain_q   <= '0;
      vlim_q   <= LIMIT_RESET;
      ilim_q   <= LIMIT_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        REG_COEF_A:         coef_a_q <= cfg_i.data;
        REG_COEF_B:         coef_b_q <= cfg_i.data;
        REG_COEF_C:         coef_c_q <= cfg_i.data;
        REG_COEF_D:         coef_d_q <= cfg_i.data;
        REG_POSITION_GAIN:  gain_q   <= cfg_i.data;
        REG_VELOCITY_LIMIT: vlim_q   <= cfg_i.data[LIMIT_W-1:0];
        REG_CURRENT_LIMIT:  ilim_q   <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-axis PI state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) pi_state_q[i] <= '0;
    end else if (state_q == ST_SUMX) begin
      pi_state_q[axis_q] <= add_y;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q  <= in_i.action;
      axis_q    <= axis_idx;
      pref_q    <= in_i.position_ref;
      pmeas_q   <= in_i.position_meas;
      vref_in_q <= in_i.velocity_ref;
      vmeas_q   <= in_i.velocity_meas;
      x_q       <= pi_state_q[axis_idx];
    end
    unique case (state_q)
      ST_ERRP: acc_q <= add_y;
      ST_MULG: prod_q <= mul_p;
      ST_VCLP: acc_q <= vclamp[DATA_W-1:0];
      ST_ERRV: err_q <= add_y;
      ST_MULC: prod_q <= mul_p;
      ST_MULD: begin
        t_q    <= prod_sh;
        prod_q <= mul_p;
      end
      ST_SUMO: begin
        cur_q  <= add_y;
        prod_q <= mul_p;
      end
      ST_MULB: begin
        t_q    <= prod_sh;
        prod_q <= mul_p;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_cmd_q     <= iclamp[DATA_W-1:0];
      out_clamped_q <= iclamp[DATA_W];
    end
  end

endmodule

[rtl/core/cpvp_checker.sv]
// Port-level checker for the servo block, bound to the top level.
module cpvp_checker import cpvp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_cmd,
  input logic              out_clamped
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd) && $stable(out_clamped))
    else $error("stalled result changed");

  // the sequencer is busy for the cycles after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while busy");

  // no new result right after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too early");

  // reset drops the result
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid in reset");

endmodule

bind cascade_position_velocity_pi cpvp_checker u_cpvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_cmd     (out_o.current_cmd),
  .out_clamped (out_o.current_clamped)
);
